@@ src/sampled_antenna_gain_interp_core_defines.svh @@
// ---------------------------------------------------------------------------
// sampled antenna gain core: assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SAMPLED_ANTENNA_GAIN_INTERP_CORE_DEFINES_SVH
`define SAMPLED_ANTENNA_GAIN_INTERP_CORE_DEFINES_SVH

// same-cycle implication
`define SAGI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAGI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sagi_pkg.sv @@
// ---------------------------------------------------------------------------
// sagi_pkg
// types, constants and tables shared by the sampled antenna gain core
// ---------------------------------------------------------------------------
package sagi_pkg;

  localparam int MAX_SAMPLES_DEF  = 256;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_W         = 56;
  localparam int CORDIC_PRESCALE  = 20;
  localparam int SERIES_TERMS     = 12;
  localparam int GAIN_W           = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_ANGLE = CFG_IDX_W'(1);
  localparam logic [8:0]           SAMPLE_COUNT_RST   = 9'd256;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [29:0] LN2_Q30           = 30'd744261118;
  localparam logic [29:0] LOG2_10_DIV10_Q30 = 30'd356689313;
  localparam logic [30:0] ONE_Q30           = 31'h4000_0000;

  // atan(2^-i) in q32 turns
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic signed [15:0] entry_gain;
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] facing_x;
    logic signed [31:0] facing_y;
    logic signed [31:0] peer_x;
    logic signed [31:0] peer_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] gain_linear;
    logic [15:0] relative_angle;
  } out_item_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic signed [15:0] entry_gain;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] ang_los;
    logic [31:0] ang_face;
  } ang_t;

  typedef struct packed {
    logic [8:0]  sample_count;
    logic [15:0] rotation_angle;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] t;
    logic [15:0]        rel;
  } gain_t;

endpackage

@@ src/sagi_ram.sv @@
// ---------------------------------------------------------------------------
// sagi_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module sagi_ram #(
  parameter int WIDTH = sagi_pkg::GAIN_W,
  parameter int DEPTH = sagi_pkg::MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ src/sagi_cordic.sv @@
// ---------------------------------------------------------------------------
// sagi_cordic
// two-lane vectoring cordic, one rotation step per pipeline stage
// ---------------------------------------------------------------------------
module sagi_cordic #(
  parameter int STEPS = sagi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  sagi_pkg::in_item_t in_item,
  output logic               out_vld,
  output sagi_pkg::ang_t     out_ang
);

  localparam int CW = sagi_pkg::CORDIC_W;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          ang;
  } lane_t;

  typedef struct packed {
    lane_t           los;
    lane_t           face;
    sagi_pkg::side_t side;
  } stage_t;

  // scale up and fold the left half plane onto the right
  function automatic lane_t pre_lane(logic signed [32:0] vx, logic signed [32:0] vy);
    lane_t r;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    sx = CW'(vx) <<< sagi_pkg::CORDIC_PRESCALE;
    sy = CW'(vy) <<< sagi_pkg::CORDIC_PRESCALE;
    if (sx < 0) begin
      r.x   = -sx;
      r.y   = -sy;
      r.ang = 32'h8000_0000;
    end else begin
      r.x   = sx;
      r.y   = sy;
      r.ang = '0;
    end
    return r;
  endfunction

  function automatic lane_t step_lane(lane_t l, int i);
    lane_t r;
    r = l;
    if (l.y > 0) begin
      r.x   = l.x + (l.y >>> i);
      r.y   = l.y - (l.x >>> i);
      r.ang = l.ang + sagi_pkg::ATAN_TURNS[i];
    end else if (l.y < 0) begin
      r.x   = l.x - (l.y >>> i);
      r.y   = l.y + (l.x >>> i);
      r.ang = l.ang - sagi_pkg::ATAN_TURNS[i];
    end
    return r;
  endfunction

  stage_t     st_r [STEPS+1];
  stage_t     st_nxt [STEPS+1];
  logic [STEPS:0] vld_r;

  always_comb begin
    st_nxt[0].los  = pre_lane(33'(in_item.peer_x) - 33'(in_item.own_x),
                              33'(in_item.peer_y) - 33'(in_item.own_y));
    st_nxt[0].face = pre_lane(33'(in_item.facing_x), 33'(in_item.facing_y));
    st_nxt[0].side.func        = in_item.func;
    st_nxt[0].side.entry_index = in_item.entry_index;
    st_nxt[0].side.entry_gain  = in_item.entry_gain;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    always_comb begin
      st_nxt[s+1].los  = step_lane(st_r[s].los, s);
      st_nxt[s+1].face = step_lane(st_r[s].face, s);
      st_nxt[s+1].side = st_r[s].side;
    end
  end

  for (genvar s = 0; s <= STEPS; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-1:0], in_vld};
    end
  end

  assign out_vld          = vld_r[STEPS];
  assign out_ang.side     = st_r[STEPS].side;
  assign out_ang.ang_los  = st_r[STEPS].los.ang;
  assign out_ang.ang_face = st_r[STEPS].face.ang;

endmodule

@@ src/sagi_interp.sv @@
// ---------------------------------------------------------------------------
// sagi_interp
// relative angle, table lookup of two neighbor samples and linear blend
// ---------------------------------------------------------------------------
module sagi_interp #(
  parameter int MAX_SAMPLES = sagi_pkg::MAX_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  sagi_pkg::cfg_t  cfg,
  input  logic            in_vld,
  input  sagi_pkg::ang_t  in_ang,
  output logic            out_vld,
  output sagi_pkg::gain_t out_gain
);

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int NW     = $clog2(MAX_SAMPLES + 1);
  localparam int PW     = 16 + NW;

  logic [NW-1:0] n;

  always_comb begin
    priority if (cfg.sample_count == '0) begin
      n = NW'(1);
    end else if (32'(cfg.sample_count) > MAX_SAMPLES) begin
      n = NW'(MAX_SAMPLES);
    end else begin
      n = NW'(cfg.sample_count);
    end
  end

  // stage 0: relative angle
  logic [15:0]     los16, face16, rel0_nxt;
  logic            vld0_r;
  logic [15:0]     rel0_r;
  sagi_pkg::side_t side0_r;

  assign los16    = 16'((in_ang.ang_los + 32'h0000_8000) >> 16);
  assign face16   = 16'((in_ang.ang_face + 32'h0000_8000) >> 16);
  assign rel0_nxt = los16 - face16 - cfg.rotation_angle;

  // stage 1: table position
  logic [PW-1:0]   p1_nxt, p1_r;
  logic            vld1_r;
  logic [15:0]     rel1_r;
  sagi_pkg::side_t side1_r;

  assign p1_nxt = PW'(rel0_r) * PW'(n);

  // stage 2: table read and writes, kept in item order
  logic [NW-1:0]         base;
  logic [NW:0]           base_inc;
  logic [NW-1:0]         nidx;
  logic [ADDR_W+7:0]     widx;
  logic                  we;
  logic [15:0]           rd0, rd1;
  logic                  vld2_r;
  logic [15:0]           frac2_r, rel2_r;

  assign base     = p1_r[PW-1:16];
  assign base_inc = {1'b0, base} + (NW+1)'(1);
  assign nidx     = (base_inc >= {1'b0, n}) ? '0 : base_inc[NW-1:0];
  assign widx     = (ADDR_W+8)'(side1_r.entry_index);
  assign we       = en && vld1_r && (side1_r.func == sagi_pkg::FUNC_WRITE) &&
                    (32'(side1_r.entry_index) < MAX_SAMPLES);

  sagi_ram #(.WIDTH(sagi_pkg::GAIN_W), .DEPTH(MAX_SAMPLES)) u_ram_base (
    .clk   (clk),
    .we    (we),
    .waddr (widx[ADDR_W-1:0]),
    .wdata (side1_r.entry_gain),
    .re    (en),
    .raddr (base[ADDR_W-1:0]),
    .rdata (rd0)
  );

  sagi_ram #(.WIDTH(sagi_pkg::GAIN_W), .DEPTH(MAX_SAMPLES)) u_ram_next (
    .clk   (clk),
    .we    (we),
    .waddr (widx[ADDR_W-1:0]),
    .wdata (side1_r.entry_gain),
    .re    (en),
    .raddr (nidx[ADDR_W-1:0]),
    .rdata (rd1)
  );

  // stage 3: blend in 2^-24 db
  logic signed [15:0] g0, g1;
  logic signed [16:0] diff;
  logic signed [33:0] prod, tsum;
  logic signed [31:0] t3_nxt, t3_r;
  logic               vld3_r;
  logic [15:0]        rel3_r;

  always_comb begin
    g0     = $signed(rd0);
    g1     = $signed(rd1);
    diff   = 17'(g1) - 17'(g0);
    prod   = 34'(diff) * 34'($signed({1'b0, frac2_r}));
    tsum   = (34'(g0) <<< 16) + prod;
    t3_nxt = 32'(tsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r && (side1_r.func == sagi_pkg::FUNC_QUERY);
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel0_r  <= rel0_nxt;
      side0_r <= in_ang.side;
      p1_r    <= p1_nxt;
      rel1_r  <= rel0_r;
      side1_r <= side0_r;
      frac2_r <= p1_r[15:0];
      rel2_r  <= rel1_r;
      t3_r    <= t3_nxt;
      rel3_r  <= rel2_r;
    end
  end

  assign out_vld      = vld3_r;
  assign out_gain.t   = t3_r;
  assign out_gain.rel = rel3_r;

endmodule

@@ src/sagi_exp.sv @@
// ---------------------------------------------------------------------------
// sagi_exp
// db to linear q16.16: log2 scaling, pipelined power series, final shift
// ---------------------------------------------------------------------------
module sagi_exp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  sagi_pkg::gain_t     in_gain,
  output logic                out_vld,
  output sagi_pkg::out_item_t out_item
);

  localparam int TERMS = sagi_pkg::SERIES_TERMS;

  typedef struct packed {
    logic [29:0]       x;
    logic signed [7:0] k;
    logic [15:0]       rel;
    logic [31:0]       sum;
    logic [30:0]       term;
  } ser_t;

  // e0: scale to log2 units
  logic signed [61:0] tc0_nxt, tc0_r;
  logic [15:0]        rel0_r;
  logic               vld0_r;

  assign tc0_nxt = 62'(in_gain.t) * 62'($signed({1'b0, sagi_pkg::LOG2_10_DIV10_Q30}));

  // e1: integer and fraction of the exponent
  logic signed [37:0] l1;
  logic signed [7:0]  k1_nxt, k1_r;
  logic [29:0]        f1_r;
  logic [15:0]        rel1_r;
  logic               vld1_r;

  assign l1     = 38'(tc0_r >>> 24);
  assign k1_nxt = 8'(l1 >>> 30);

  // e2: series argument f * ln2
  logic [59:0] xprod;
  ser_t        head_nxt;

  assign xprod = 60'(f1_r) * 60'(sagi_pkg::LN2_Q30);

  always_comb begin
    head_nxt.x    = xprod[59:30];
    head_nxt.k    = k1_r;
    head_nxt.rel  = rel1_r;
    head_nxt.sum  = 32'(sagi_pkg::ONE_Q30);
    head_nxt.term = sagi_pkg::ONE_Q30;
  end

  ser_t ch_r   [TERMS+1];
  logic chv_r  [TERMS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r   <= 1'b0;
      vld1_r   <= 1'b0;
      chv_r[0] <= 1'b0;
    end else if (en) begin
      vld0_r   <= in_vld;
      vld1_r   <= vld0_r;
      chv_r[0] <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc0_r   <= tc0_nxt;
      rel0_r  <= in_gain.rel;
      k1_r    <= k1_nxt;
      f1_r    <= l1[29:0];
      rel1_r  <= rel0_r;
      ch_r[0] <= head_nxt;
    end
  end

  // each term: multiply, reciprocal divide, one-step correction and accumulate
  for (genvar s = 0; s < TERMS; s++) begin : g_term
    localparam int J = s + 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / J);

    ser_t        a_r, b_r, c_nxt;
    logic        a_vld_r, b_vld_r;
    logic [30:0] a_v_r, b_v_r, b_q_r;
    logic [60:0] a_prod;
    logic [62:0] b_prod;
    logic [34:0] c_rem;
    logic [30:0] c_q;

    assign a_prod = 61'(ch_r[s].term) * 61'(ch_r[s].x);
    assign b_prod = 63'(a_v_r) * 63'(RECIP);

    always_comb begin
      c_rem      = 35'(b_v_r) - 35'(b_q_r) * 35'(J);
      c_q        = (c_rem >= 35'(J)) ? b_q_r + 31'd1 : b_q_r;
      c_nxt      = b_r;
      c_nxt.term = c_q;
      c_nxt.sum  = b_r.sum + 32'(c_q);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r    <= 1'b0;
        b_vld_r    <= 1'b0;
        chv_r[s+1] <= 1'b0;
      end else if (en) begin
        a_vld_r    <= chv_r[s];
        b_vld_r    <= a_vld_r;
        chv_r[s+1] <= b_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r        <= ch_r[s];
        a_v_r      <= a_prod[60:30];
        b_r        <= a_r;
        b_v_r      <= a_v_r;
        b_q_r      <= b_prod[61:31];
        ch_r[s+1]  <= c_nxt;
      end
    end
  end

  // final scaling by 2^(k-14) with round half up
  ser_t                fin;
  logic signed [8:0]   sh;
  logic [5:0]          shamt;
  logic [33:0]         rnd;
  logic [31:0]         lin;
  logic                fin_vld_r;
  sagi_pkg::out_item_t fin_r;

  assign fin = ch_r[TERMS];

  always_comb begin
    sh    = 9'sd14 - 9'(fin.k);
    shamt = sh[5:0];
    rnd   = (34'(fin.sum) + (34'd1 << (shamt - 6'd1))) >> shamt;
    priority if (fin.k >= 8'sd16) begin
      lin = '1;
    end else if (fin.k == 8'sd15) begin
      lin = {fin.sum[30:0], 1'b0};
    end else if (fin.k == 8'sd14) begin
      lin = fin.sum;
    end else if (sh > 9'sd33) begin
      lin = '0;
    end else begin
      lin = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= chv_r[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r.gain_linear    <= lin;
      fin_r.relative_angle <= fin.rel;
    end
  end

  assign out_vld  = fin_vld_r;
  assign out_item = fin_r;

endmodule

@@ src/sampled_antenna_gain_interp_core.sv @@
// ---------------------------------------------------------------------------
// sampled_antenna_gain_interp_core
// antenna gain from a sampled pattern, looked up toward a peer node
//
// One transaction enters per clock while in_stall is low: a table write or a
// gain query. Queries return one result after CORDIC_STEPS + 1 cordic stages,
// 4 lookup stages, 40 db to linear series stages and 1 output stage; writes
// return nothing and take effect in order with the queries around them. The
// pipeline stalls as a whole only while the one-deep skid behind the output
// register is full; it fills when out_stall holds a result. The gain table is
// not cleared after reset and must be written before it is queried. Config
// writes are taken every cycle and must only be issued while the core is idle.
// ---------------------------------------------------------------------------
`include "sampled_antenna_gain_interp_core_defines.svh"

module sampled_antenna_gain_interp_core #(
  parameter int MAX_SAMPLES  = sagi_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = sagi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sagi_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sagi_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sagi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sagi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sagi_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count   <= sagi_pkg::SAMPLE_COUNT_RST;
      cfg_r.rotation_angle <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sagi_pkg::CFG_SAMPLE_COUNT:   cfg_r.sample_count   <= cfg_data[8:0];
        sagi_pkg::CFG_ROTATION_ANGLE: cfg_r.rotation_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic en;
  logic skid_vld_r;

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  logic                cor_vld;
  sagi_pkg::ang_t      cor_ang;
  logic                int_vld;
  sagi_pkg::gain_t     int_gain;
  logic                p_vld;
  sagi_pkg::out_item_t p_item;

  sagi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_item (in_item),
    .out_vld (cor_vld),
    .out_ang (cor_ang)
  );

  sagi_interp #(.MAX_SAMPLES(MAX_SAMPLES)) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_vld   (cor_vld),
    .in_ang   (cor_ang),
    .out_vld  (int_vld),
    .out_gain (int_gain)
  );

  sagi_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (int_vld),
    .in_gain  (int_gain),
    .out_vld  (p_vld),
    .out_item (p_item)
  );

  // output register with a one-deep skid behind it
  logic                out_vld_r, out_vld_nxt, skid_vld_nxt, take;
  sagi_pkg::out_item_t out_item_r, out_item_nxt, skid_item_r, skid_item_nxt;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_item_nxt  = out_item_r;
    skid_vld_nxt  = skid_vld_r;
    skid_item_nxt = skid_item_r;
    take          = en && p_vld;
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_item_nxt = skid_item_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = take;
        out_item_nxt = p_item;
      end
    end else if (take) begin
      skid_vld_nxt  = 1'b1;
      skid_item_nxt = p_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  `SAGI_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid full with output empty")
  `SAGI_ASSERT_IMP(a_skid_fill_cause, $rose(skid_vld_r), $past(out_vld_r && out_stall), "skid filled without a held output")
  `SAGI_ASSERT_NXT(a_skid_drain, skid_vld_r && !out_stall, !skid_vld_r, "skid did not drain")

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// sampled antenna gain core testbench
// fills the gain table, then sends directed and random queries and table
// writes under several sample count and rotation settings; every result is
// predicted in the bench and checked in order
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY_WAIT = sagi_pkg::CORDIC_STEPS_DEF + 60;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IN_W         = $bits(sagi_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sagi_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sagi_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sagi_pkg::CFG_IDX_W-1:0] cfg_index = sagi_pkg::CFG_SAMPLE_COUNT;
  logic [sagi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sagi_pkg::in_item_t pending_items[$];
  sagi_pkg::out_item_t expected_gains[$];
  logic [15:0] gain_shadow [sagi_pkg::MAX_SAMPLES_DEF];
  logic [8:0] count_shadow = sagi_pkg::SAMPLE_COUNT_RST;
  logic [15:0] rotation_shadow = '0;
  int errors = 0;
  int cfg_writes = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  sampled_antenna_gain_interp_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // angle of (x, y) in 16-bit turns, fixed-length cordic
  function automatic logic [15:0] turn_angle(longint x, longint y);
    logic [31:0] ang;
    longint dx, dy;
    ang = '0;
    if (x == 0 && y == 0) return '0;
    x = x <<< 20;
    y = y <<< 20;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < sagi_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += sagi_pkg::ATAN_TURNS[i];
      end else if (y < 0) begin
        x -= dx; y += dy; ang -= sagi_pkg::ATAN_TURNS[i];
      end
    end
    ang = ang + 32'h8000;
    return ang[31:16];
  endfunction

  // t in 2^-24 dB to linear unsigned q16.16
  function automatic logic [31:0] db_to_linear(longint t);
    longint l, k, s;
    logic [63:0] f, x, term, total;
    l = (t * 64'sd356689313) >>> 24;
    k = l >>> 30;
    f = 64'(l - (k <<< 30));
    x = (f * 64'd744261118) >> 30;
    term = 64'h4000_0000;
    total = term;
    for (int j = 1; j <= sagi_pkg::SERIES_TERMS; j++) begin
      term = ((term * x) >> 30) / j;
      total += term;
    end
    if (k >= 16) return 32'hFFFF_FFFF;
    if (k >= 14) return 32'(total << (k - 14));
    s = 14 - k;
    if (s >= 63) return '0;
    return 32'((total + (64'd1 << (s - 1))) >> s);
  endfunction

  function automatic void predict_gain(sagi_pkg::in_item_t it);
    logic [15:0] rel;
    logic [31:0] p, n, base, nxt, frac;
    longint g0, g1, t;
    sagi_pkg::out_item_t r;
    if (it.func == sagi_pkg::FUNC_WRITE) begin
      gain_shadow[it.entry_index] = it.entry_gain;
      return;
    end
    rel = turn_angle(longint'(it.peer_x) - longint'(it.own_x),
                     longint'(it.peer_y) - longint'(it.own_y))
          - turn_angle(longint'(it.facing_x), longint'(it.facing_y)) - rotation_shadow;
    n = (count_shadow == 0) ? 1 :
        (count_shadow > sagi_pkg::MAX_SAMPLES_DEF ? sagi_pkg::MAX_SAMPLES_DEF
                                                  : count_shadow);
    p = rel * n;
    base = p >> 16;
    frac = p & 32'hFFFF;
    nxt = (base + 1 >= n) ? 0 : base + 1;
    g0 = longint'($signed(gain_shadow[base]));
    g1 = longint'($signed(gain_shadow[nxt]));
    t = g0 * 65536 + (g1 - g0) * longint'(frac);
    r.gain_linear = db_to_linear(t);
    r.relative_angle = rel;
    expected_gains.push_back(r);
  endfunction

  // input driver
  always @(posedge clk) begin : drive_in
    if (rst_n) begin
      if (in_valid && !in_stall) predict_gain(in_item);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : watch_out
    sagi_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_gains.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          errors++;
        end else begin
          want = expected_gains.pop_front();
          if (out_item.gain_linear !== want.gain_linear) begin
            $display("%0t: gain_linear expected %h actual %h", $time,
                     want.gain_linear, out_item.gain_linear);
            errors++;
          end
          if (out_item.relative_angle !== want.relative_angle) begin
            $display("%0t: relative_angle expected %h actual %h", $time,
                     want.relative_angle, out_item.relative_angle);
            errors++;
          end
        end
      end
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        hold_cnt++;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // config write acceptance
  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == sagi_pkg::CFG_SAMPLE_COUNT) count_shadow = cfg_data[8:0];
      else if (cfg_index == sagi_pkg::CFG_ROTATION_ANGLE) rotation_shadow = cfg_data;
      cfg_valid <= 1'b0;
      cfg_writes++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [sagi_pkg::CFG_IDX_W-1:0] idx,
                           logic [sagi_pkg::CFG_DATA_W-1:0] val);
    int seen;
    seen = cfg_writes;
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    while (cfg_writes == seen) @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_gains.size() > 0);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  function automatic sagi_pkg::in_item_t table_write(logic [7:0] idx, logic [15:0] g);
    sagi_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = sagi_pkg::FUNC_WRITE;
    it.entry_index = idx;
    it.entry_gain = g;
    return it;
  endfunction

  function automatic sagi_pkg::in_item_t query(int ox, int oy, int fx, int fy,
                                               int px, int py);
    sagi_pkg::in_item_t it;
    it.func = sagi_pkg::FUNC_QUERY;
    it.entry_index = 8'($urandom);
    it.entry_gain = 16'($urandom);
    it.own_x = ox; it.own_y = oy;
    it.facing_x = fx; it.facing_y = fy;
    it.peer_x = px; it.peer_y = py;
    return it;
  endfunction

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 20480)) - 10240);
      default: return 16'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic int coord(int mode);
    if (mode == 0) return $urandom;
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic sagi_pkg::in_item_t random_item();
    sagi_pkg::in_item_t it;
    int m, ox, oy;
    if ($urandom_range(0, 99) < 15) return table_write(8'($urandom), random_gain());
    m = $urandom_range(0, 1);
    ox = coord(m);
    oy = coord(m);
    it = query(ox, oy, coord($urandom_range(0, 1)), coord($urandom_range(0, 1)),
               coord(m), coord(m));
    case ($urandom_range(0, 9))
      0: begin it.peer_x = ox; it.peer_y = oy; end
      1: begin it.facing_x = 0; it.facing_y = 0; end
      2: it.facing_y = 0;
      3: it.peer_x = ox;
      default: ;
    endcase
    return it;
  endfunction

  localparam int PHASES = 8;
  int counts [PHASES] = '{256, 1, 0, 511, 7, 255, 2, 100};
  int rotations [PHASES] = '{0, 65535, 16384, 12345, 32768, 1, 49152, 777};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < sagi_pkg::MAX_SAMPLES_DEF; i++)
      pending_items.push_back(table_write(8'(i), random_gain()));
    wait_idle();
    write_reg(sagi_pkg::CFG_SAMPLE_COUNT, 16'd256);
    write_reg(sagi_pkg::CFG_ROTATION_ANGLE, 16'd0);
    @(negedge clk);
    // directed: extreme gains, zero vectors, axes and coordinate extremes
    pending_items.push_back(table_write(8'd0, 16'h7FFF));
    pending_items.push_back(table_write(8'd255, 16'h8000));
    pending_items.push_back(query(0, 0, 0, 0, 0, 0));
    pending_items.push_back(query(5, 5, 1, 0, 5, 5));
    pending_items.push_back(query(0, 0, 0, 0, 100, 0));
    pending_items.push_back(query(0, 0, 1, 0, 100, 0));
    pending_items.push_back(query(0, 0, 1, 0, -100, 0));
    pending_items.push_back(query(0, 0, 1, 0, 0, 100));
    pending_items.push_back(query(0, 0, 1, 0, 0, -100));
    pending_items.push_back(query(0, 0, 1, 0, -100, -1));
    pending_items.push_back(query(0, 0, 1, 0, 100, -1));
    pending_items.push_back(query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_items.push_back(query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(query(0, 0, 32'h8000_0000, 32'h8000_0000, -1, -1));
    pending_items.push_back(query(0, 0, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 1));
    pending_items.push_back(query(0, 0, 0, 1, 3, 4));
    wait_idle();
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(sagi_pkg::CFG_SAMPLE_COUNT, 16'(counts[ph]));
      write_reg(sagi_pkg::CFG_ROTATION_ANGLE, 16'(rotations[ph]));
      @(negedge clk);
      quiet = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 170; i++) pending_items.push_back(random_item());
      wait_idle();
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
